// ----- rtl/tcce_pkg.sv -----
// Shared types and constants for the text canvas cursor engine.
// Holds the item structs, command classes and register indexes; no dependencies.
package tcce_pkg;

  typedef struct packed {
    logic [3:0] mode;
    logic [7:0] char_code;
    logic [7:0] move_count;
    logic [7:0] target_col;
    logic [7:0] target_row;
    logic [2:0] fore_color;
    logic [2:0] back_color;
    logic       bold_on;
    logic       blink_on;
    logic       reverse_on;
    logic       hidden_on;
    logic       wrap_on;
  } in_t;

  typedef struct packed {
    logic [6:0] report_col;
    logic [7:0] report_row;
    logic [7:0] cur_line;
    logic [8:0] used_lines;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
    logic       line_overflow;
  } out_t;

  // Command classes produced by the front end.
  typedef enum logic [4:0] {
    OP_NOP, OP_BS, OP_TAB, OP_LF, OP_CR, OP_GLYPH,
    OP_UP, OP_DOWN, OP_LEFT, OP_RIGHT, OP_GOTO, OP_ATTR,
    OP_CLR_EOL, OP_CLR_BOL, OP_CLR_LINE, OP_CLR_EOS, OP_CLR_BOS, OP_CLR_SCR,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t op;
    in_t item;
  } cmd_t;

  typedef struct packed {
    logic [7:0] line_width;
    logic [7:0] screen_height;
    logic [7:0] tab_width;
  } cfg_t;

  typedef struct packed {
    logic       en;
    logic [1:0] idx;
    logic [7:0] val;
  } cfg_wr_t;

  localparam logic [1:0] REG_LINE_WIDTH    = 2'd0;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [1:0] REG_TAB_WIDTH     = 2'd2;

  localparam logic [3:0] MODE_PUT      = 4'd0;
  localparam logic [3:0] MODE_UP       = 4'd1;
  localparam logic [3:0] MODE_DOWN     = 4'd2;
  localparam logic [3:0] MODE_LEFT     = 4'd3;
  localparam logic [3:0] MODE_RIGHT    = 4'd4;
  localparam logic [3:0] MODE_GOTO     = 4'd5;
  localparam logic [3:0] MODE_ATTR     = 4'd6;
  localparam logic [3:0] MODE_CLR_EOL  = 4'd7;
  localparam logic [3:0] MODE_CLR_BOL  = 4'd8;
  localparam logic [3:0] MODE_CLR_LINE = 4'd9;
  localparam logic [3:0] MODE_CLR_EOS  = 4'd10;
  localparam logic [3:0] MODE_CLR_BOS  = 4'd11;
  localparam logic [3:0] MODE_CLR_SCR  = 4'd12;
  localparam logic [3:0] MODE_READ     = 4'd13;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_BEL = 8'h07;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_ESC = 8'h1b;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [15:0] BLANK_CELL = 16'h0720;

endpackage

// ----- rtl/tcce_front.sv -----
// Front end: accepts commands, classifies them and queues them for the back end.
// Depends on tcce_pkg.
module tcce_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  tcce_pkg::in_t     in_item,
  input  logic              init_busy,
  output logic              busy,
  output logic              q_valid,
  output tcce_pkg::cmd_t    q_head,
  input  logic              q_pop
);

  tcce_pkg::cmd_t q_mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  tcce_pkg::op_t op_cls;

  always_comb begin
    op_cls = tcce_pkg::OP_NOP;
    case (in_item.mode)
      tcce_pkg::MODE_PUT: begin
        case (in_item.char_code)
          tcce_pkg::CH_NUL, tcce_pkg::CH_BEL, tcce_pkg::CH_ESC: op_cls = tcce_pkg::OP_NOP;
          tcce_pkg::CH_BS:  op_cls = tcce_pkg::OP_BS;
          tcce_pkg::CH_TAB: op_cls = tcce_pkg::OP_TAB;
          tcce_pkg::CH_LF:  op_cls = tcce_pkg::OP_LF;
          tcce_pkg::CH_CR:  op_cls = tcce_pkg::OP_CR;
          default:          op_cls = tcce_pkg::OP_GLYPH;
        endcase
      end
      tcce_pkg::MODE_UP:       op_cls = tcce_pkg::OP_UP;
      tcce_pkg::MODE_DOWN:     op_cls = tcce_pkg::OP_DOWN;
      tcce_pkg::MODE_LEFT:     op_cls = tcce_pkg::OP_LEFT;
      tcce_pkg::MODE_RIGHT:    op_cls = tcce_pkg::OP_RIGHT;
      tcce_pkg::MODE_GOTO:     op_cls = tcce_pkg::OP_GOTO;
      tcce_pkg::MODE_ATTR:     op_cls = tcce_pkg::OP_ATTR;
      tcce_pkg::MODE_CLR_EOL:  op_cls = tcce_pkg::OP_CLR_EOL;
      tcce_pkg::MODE_CLR_BOL:  op_cls = tcce_pkg::OP_CLR_BOL;
      tcce_pkg::MODE_CLR_LINE: op_cls = tcce_pkg::OP_CLR_LINE;
      tcce_pkg::MODE_CLR_EOS:  op_cls = tcce_pkg::OP_CLR_EOS;
      tcce_pkg::MODE_CLR_BOS:  op_cls = tcce_pkg::OP_CLR_BOS;
      tcce_pkg::MODE_CLR_SCR:  op_cls = tcce_pkg::OP_CLR_SCR;
      tcce_pkg::MODE_READ:     op_cls = tcce_pkg::OP_READ;
      default:                 op_cls = tcce_pkg::OP_NOP;
    endcase
  end

  assign busy    = (cnt_r == 2'd2) || init_busy;
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_head  = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ (q_pop && q_valid);
    cnt_nxt    = cnt_r + 2'(push) - 2'(q_pop && q_valid);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= '{op: op_cls, item: in_item};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/tcce_back.sv -----
// Back end: cursor state, the cell memory and the command sequencer.
// Depends on tcce_pkg.
module tcce_back #(
  parameter int MAX_LINES = 256,
  parameter int MAX_COLS  = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tcce_pkg::cfg_t    cfg,
  input  tcce_pkg::cfg_wr_t cfg_wr,
  input  logic              q_valid,
  input  tcce_pkg::cmd_t    q_head,
  output logic              q_pop,
  output logic              init_busy,
  output logic              out_strobe,
  output tcce_pkg::out_t    out_item
);

  localparam int LB    = $clog2(MAX_LINES);
  localparam int HW    = $clog2(MAX_LINES + 1);
  localparam int CB    = $clog2(MAX_COLS);
  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int AW    = LB + CB;
  localparam int DEPTH = 1 << AW;

  typedef enum logic [8:0] {
    S_INIT   = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_PWRAP  = 9'b000000100,
    S_OP     = 9'b000001000,
    S_TABMOD = 9'b000010000,
    S_EMIT   = 9'b000100000,
    S_SPAN   = 9'b001000000,
    S_LINES  = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t          state_r, state_nxt;
  tcce_pkg::cmd_t  cmd_r, cmd_nxt;
  logic [CW-1:0]   col_r, col_nxt;
  logic [LB-1:0]   line_r, line_nxt;
  logic [7:0]      row_r, row_nxt;
  logic [HW-1:0]   hused_r, hused_nxt;
  logic [2:0]      fg_r, fg_nxt, bg_r, bg_nxt;
  logic [4:0]      flags_r, flags_nxt;
  logic            ovf_r, ovf_nxt;
  logic [CW-1:0]   rem_r, rem_nxt;
  logic [CW-1:0]   wc_r, wc_nxt, we_r, we_nxt;
  logic [HW-1:0]   wl_r, wl_nxt, le_r, le_nxt;
  logic [AW-1:0]   init_addr_r, init_addr_nxt;
  logic            strobe_r, strobe_nxt;
  tcce_pkg::out_t  out_r, out_nxt;

  logic [15:0]     mem [DEPTH];
  logic [15:0]     rdata_r;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr, rd_addr;
  logic [15:0]     mem_wdata;

  logic [CW-1:0]   w, t;
  logic [7:0]      h;

  function automatic logic [CW-1:0] f_effw(input logic [7:0] v);
    if (v == 8'd0) return CW'(1);
    if (32'(v) > MAX_COLS) return CW'(MAX_COLS);
    return CW'(v);
  endfunction

  function automatic logic [7:0] f_effh(input logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

  // Returns {overflow, line} for a downward line move with saturation.
  function automatic logic [LB:0] f_down(input logic [LB-1:0] ln, input logic [7:0] n);
    logic [31:0] s;
    s = 32'(ln) + 32'(n);
    if (s > 32'(MAX_LINES - 1)) return {1'b1, LB'(MAX_LINES - 1)};
    return {1'b0, s[LB-1:0]};
  endfunction

  function automatic logic [LB-1:0] f_up(input logic [LB-1:0] ln, input logic [7:0] n);
    if (32'(n) > 32'(ln)) return '0;
    return ln - LB'(n);
  endfunction

  function automatic logic [7:0] f_attr(input logic [2:0] f, input logic [2:0] b,
                                        input logic [4:0] fl);
    logic [3:0] fo, bo;
    fo = {1'b0, f};
    bo = {1'b0, b};
    if (fl[2]) begin
      if (fl[3]) bo = {1'b0, f};
      else begin
        fo = {1'b0, b};
        bo = {1'b0, f};
      end
    end else if (fl[3]) begin
      fo = {1'b0, b};
    end
    if (fl[0]) fo[3] = 1'b1;
    if (fl[1]) bo[3] = 1'b1;
    return {bo, fo};
  endfunction

  always_comb begin
    w = f_effw(cfg.line_width);
    h = f_effh(cfg.screen_height);
    t = (cfg.tab_width == 8'd0) ? CW'(1) : CW'(cfg.tab_width);
    if (t > w) t = w;
  end

  // Read address for the read command; the sequencer holds cmd_r while it is used.
  always_comb begin
    logic [CW-1:0] rx;
    logic [LB-1:0] ry;
    rx = (32'(cmd_r.item.target_col) >= 32'(w)) ? w - CW'(1) : CW'(cmd_r.item.target_col);
    ry = (32'(cmd_r.item.target_row) > 32'(MAX_LINES - 1)) ? LB'(MAX_LINES - 1)
                                                           : LB'(cmd_r.item.target_row);
    rd_addr = {ry, rx[CB-1:0]};
  end

  always_comb begin
    logic [LB:0]   dn;
    logic [7:0]    nm, lim;
    logic [CW-1:0] cl, nw, ph;
    logic [7:0]    ty, nh;
    logic [LB-1:0] top;

    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    col_nxt       = col_r;
    line_nxt      = line_r;
    row_nxt       = row_r;
    hused_nxt     = hused_r;
    fg_nxt        = fg_r;
    bg_nxt        = bg_r;
    flags_nxt     = flags_r;
    ovf_nxt       = ovf_r;
    rem_nxt       = rem_r;
    wc_nxt        = wc_r;
    we_nxt        = we_r;
    wl_nxt        = wl_r;
    le_nxt        = le_r;
    init_addr_nxt = init_addr_r;
    strobe_nxt    = 1'b0;
    out_nxt       = out_r;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = tcce_pkg::BLANK_CELL;
    dn = '0; nm = '0; lim = '0; cl = '0; nw = '0; ph = '0; ty = '0; nh = '0;
    top = (32'(row_r) > 32'(line_r)) ? '0 : line_r - LB'(row_r);

    case (state_r)
      S_INIT: begin
        mem_we        = 1'b1;
        mem_waddr     = init_addr_r;
        init_addr_nxt = init_addr_r + AW'(1);
        if (init_addr_r == {AW{1'b1}}) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_head;
          state_nxt = S_PWRAP;
        end
      end
      S_PWRAP: begin
        // A pending wrap is resolved before backspace and before moves with a nonzero count.
        if (((cmd_r.op inside {tcce_pkg::OP_UP, tcce_pkg::OP_DOWN, tcce_pkg::OP_LEFT,
                               tcce_pkg::OP_RIGHT}) && cmd_r.item.move_count != 8'd0 ||
             cmd_r.op == tcce_pkg::OP_BS) && col_r >= w) begin
          col_nxt = '0;
          dn = f_down(line_r, 8'd1);
          line_nxt = dn[LB-1:0];
          if (dn[LB]) ovf_nxt = 1'b1;
          if (32'(row_r) + 1 < 32'(h)) row_nxt = row_r + 8'd1;
        end
        state_nxt = S_OP;
      end
      S_OP: begin
        nm = cmd_r.item.move_count;
        state_nxt = S_DONE;
        case (cmd_r.op)
          tcce_pkg::OP_BS: if (col_r != '0) col_nxt = col_r - CW'(1);
          tcce_pkg::OP_TAB: begin
            rem_nxt   = col_r;
            state_nxt = S_TABMOD;
          end
          tcce_pkg::OP_LF: begin
            dn = f_down(line_r, 8'd1);
            line_nxt = dn[LB-1:0];
            if (dn[LB]) ovf_nxt = 1'b1;
            if (32'(row_r) + 1 < 32'(h)) row_nxt = row_r + 8'd1;
          end
          tcce_pkg::OP_CR: col_nxt = '0;
          tcce_pkg::OP_GLYPH: state_nxt = S_EMIT;
          tcce_pkg::OP_UP: begin
            if (nm > row_r) nm = row_r;
            line_nxt = f_up(line_r, nm);
            row_nxt  = row_r - nm;
          end
          tcce_pkg::OP_DOWN: begin
            lim = (32'(row_r) + 1 < 32'(h)) ? h - row_r - 8'd1 : 8'd0;
            if (nm > lim) nm = lim;
            dn = f_down(line_r, nm);
            line_nxt = dn[LB-1:0];
            if (dn[LB]) ovf_nxt = 1'b1;
            row_nxt = row_r + nm;
          end
          tcce_pkg::OP_LEFT: begin
            cl = (32'(nm) > 32'(col_r)) ? col_r : CW'(nm);
            col_nxt = col_r - cl;
          end
          tcce_pkg::OP_RIGHT: begin
            cl = (32'(col_r) + 1 < 32'(w)) ? w - col_r - CW'(1) : '0;
            if (32'(nm) < 32'(cl)) cl = CW'(nm);
            col_nxt = col_r + cl;
          end
          tcce_pkg::OP_GOTO: begin
            col_nxt = (32'(cmd_r.item.target_col) >= 32'(w)) ? w - CW'(1)
                                                            : CW'(cmd_r.item.target_col);
            ty = (cmd_r.item.target_row >= h) ? h - 8'd1 : cmd_r.item.target_row;
            if (ty >= row_r) begin
              dn = f_down(line_r, ty - row_r);
              line_nxt = dn[LB-1:0];
              if (dn[LB]) ovf_nxt = 1'b1;
            end else begin
              line_nxt = f_up(line_r, row_r - ty);
            end
            row_nxt = ty;
          end
          tcce_pkg::OP_ATTR: begin
            fg_nxt    = cmd_r.item.fore_color;
            bg_nxt    = cmd_r.item.back_color;
            flags_nxt = {cmd_r.item.wrap_on, cmd_r.item.hidden_on, cmd_r.item.reverse_on,
                         cmd_r.item.blink_on, cmd_r.item.bold_on};
          end
          tcce_pkg::OP_CLR_EOL, tcce_pkg::OP_CLR_BOL, tcce_pkg::OP_CLR_LINE,
          tcce_pkg::OP_CLR_EOS, tcce_pkg::OP_CLR_BOS, tcce_pkg::OP_CLR_SCR: begin
            wc_nxt = '0;
            we_nxt = w;
            wl_nxt = '0;
            le_nxt = '0;
            state_nxt = S_SPAN;
            case (cmd_r.op)
              tcce_pkg::OP_CLR_EOL: wc_nxt = col_r;
              tcce_pkg::OP_CLR_BOL: we_nxt = col_r;
              tcce_pkg::OP_CLR_EOS: begin
                wc_nxt = col_r;
                wl_nxt = HW'(line_r) + HW'(1);
                le_nxt = hused_r;
              end
              tcce_pkg::OP_CLR_BOS: begin
                we_nxt = col_r;
                if (row_r != 8'd0) begin
                  wl_nxt = HW'(top);
                  le_nxt = HW'(line_r);
                end
              end
              tcce_pkg::OP_CLR_SCR: begin
                we_nxt = '0;
                wl_nxt = HW'(top);
                le_nxt = hused_r;
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      S_TABMOD: begin
        // Reduce the column to its tab phase by repeated subtraction.
        if (rem_r >= t) rem_nxt = rem_r - t;
        else state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (col_r >= w) begin
          if (!flags_r[4]) state_nxt = S_DONE;
          else begin
            col_nxt = '0;
            rem_nxt = '0;
            dn = f_down(line_r, 8'd1);
            line_nxt = dn[LB-1:0];
            if (dn[LB]) ovf_nxt = 1'b1;
            if (32'(row_r) + 1 < 32'(h)) row_nxt = row_r + 8'd1;
          end
        end else begin
          mem_we    = 1'b1;
          mem_waddr = {line_r, col_r[CB-1:0]};
          mem_wdata = {f_attr(fg_r, bg_r, flags_r),
                       (cmd_r.op == tcce_pkg::OP_TAB) ? tcce_pkg::CH_SPACE
                                                      : cmd_r.item.char_code};
          col_nxt = col_r + CW'(1);
          if (32'(line_r) >= 32'(hused_r)) hused_nxt = HW'(line_r) + HW'(1);
          state_nxt = S_DONE;
          if (cmd_r.op == tcce_pkg::OP_TAB) begin
            ph = (rem_r + CW'(1) == t) ? '0 : rem_r + CW'(1);
            rem_nxt = ph;
            if (ph != '0) state_nxt = S_EMIT;
          end
        end
      end
      S_SPAN: begin
        if (wc_r < we_r) begin
          mem_we    = 1'b1;
          mem_waddr = {line_r, wc_r[CB-1:0]};
          wc_nxt    = wc_r + CW'(1);
        end else begin
          wc_nxt    = '0;
          state_nxt = S_LINES;
        end
      end
      S_LINES: begin
        if (wl_r < le_r) begin
          if (wc_r < w) begin
            mem_we    = 1'b1;
            mem_waddr = {wl_r[LB-1:0], wc_r[CB-1:0]};
            wc_nxt    = wc_r + CW'(1);
          end else begin
            wc_nxt = '0;
            wl_nxt = wl_r + HW'(1);
          end
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (col_r >= w) begin
          if (flags_r[4]) begin
            out_nxt.report_col = '0;
            out_nxt.report_row = (32'(row_r) + 1 < 32'(h)) ? row_r + 8'd1 : row_r;
          end else begin
            out_nxt.report_col = 7'(w - CW'(1));
            out_nxt.report_row = row_r;
          end
        end else begin
          out_nxt.report_col = 7'(col_r);
          out_nxt.report_row = row_r;
        end
        out_nxt.cur_line      = 8'(line_r);
        out_nxt.used_lines    = 9'(hused_r);
        out_nxt.cell_char     = (cmd_r.op == tcce_pkg::OP_READ) ? rdata_r[7:0] : 8'd0;
        out_nxt.cell_attr     = (cmd_r.op == tcce_pkg::OP_READ) ? rdata_r[15:8] : 8'd0;
        out_nxt.line_overflow = ovf_r;
        strobe_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    // Register writes clamp the cursor to the new geometry.
    if (cfg_wr.en) begin
      case (cfg_wr.idx)
        tcce_pkg::REG_LINE_WIDTH: begin
          nw = f_effw(cfg_wr.val);
          if (col_nxt > nw) col_nxt = nw;
        end
        tcce_pkg::REG_SCREEN_HEIGHT: begin
          nh = f_effh(cfg_wr.val);
          if (row_nxt >= nh) row_nxt = nh - 8'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    rem_r <= rem_nxt;
    wc_r  <= wc_nxt;
    we_r  <= we_nxt;
    wl_r  <= wl_nxt;
    le_r  <= le_nxt;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      col_r       <= '0;
      line_r      <= '0;
      row_r       <= '0;
      hused_r     <= '0;
      fg_r        <= 3'd7;
      bg_r        <= 3'd0;
      flags_r     <= 5'b10000;
      ovf_r       <= 1'b0;
      init_addr_r <= '0;
      strobe_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      line_r      <= line_nxt;
      row_r       <= row_nxt;
      hused_r     <= hused_nxt;
      fg_r        <= fg_nxt;
      bg_r        <= bg_nxt;
      flags_r     <= flags_nxt;
      ovf_r       <= ovf_nxt;
      init_addr_r <= init_addr_nxt;
      strobe_r    <= strobe_nxt;
    end
  end

  assign init_busy  = (state_r == S_INIT);
  assign out_strobe = strobe_r;
  assign out_item   = out_r;

  a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(line_r) < MAX_LINES) else $error("line index beyond store");
  a_hused_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(hused_r) <= MAX_LINES) else $error("used height beyond store");
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |=> !strobe_r) else $error("result strobe held two cycles");
  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |=> ovf_r) else $error("overflow flag dropped");
  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_INIT || state_r == S_EMIT || state_r == S_SPAN ||
                state_r == S_LINES)) else $error("cell write outside a write state");

endmodule

// ----- rtl/text_canvas_cursor_engine.sv -----
// Top level of the text canvas cursor engine: register port, front end and back end.
// Depends on tcce_pkg, tcce_front and tcce_back.
//
// Channel   Direction  Handshake                 Payload
// command   in         start high, busy low      in_item   (tcce_pkg::in_t)
// result    out        out_strobe, one cycle     out_item  (tcce_pkg::out_t)
// config    in/out     psel/penable/pwrite       paddr, pwdata, prdata
//
// A simple command passes through dequeue, wrap check, execute and report.
// A character write adds an emit step; a tab adds tab-phase subtractions and one write per
// cell; clears write one cell at a time, all through the single memory write port.
// After reset the cell memory is swept to blanks, one cell per cycle
// (MAX_LINES * MAX_COLS rounded up to powers of two, 32768 by default); busy stays high.
// Results cannot be stalled; a two-entry queue lets commands arrive while one executes.
module text_canvas_cursor_engine #(
  parameter int MAX_LINES = 256,
  parameter int MAX_COLS  = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tcce_pkg::in_t       in_item,
  output logic                out_strobe,
  output tcce_pkg::out_t      out_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  tcce_pkg::cfg_t    cfg_r, cfg_nxt;
  tcce_pkg::cfg_wr_t cfg_wr;
  tcce_pkg::cmd_t    q_head;
  logic              q_valid, q_pop, init_busy;

  assign pready = 1'b1;

  always_comb begin
    cfg_wr.en  = psel && penable && pwrite && pready;
    cfg_wr.idx = paddr[3:2];
    cfg_wr.val = pwdata[7:0];
    cfg_nxt    = cfg_r;
    if (cfg_wr.en) begin
      case (cfg_wr.idx)
        tcce_pkg::REG_LINE_WIDTH:    cfg_nxt.line_width    = cfg_wr.val;
        tcce_pkg::REG_SCREEN_HEIGHT: cfg_nxt.screen_height = cfg_wr.val;
        tcce_pkg::REG_TAB_WIDTH:     cfg_nxt.tab_width     = cfg_wr.val;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      tcce_pkg::REG_LINE_WIDTH:    prdata = {24'd0, cfg_r.line_width};
      tcce_pkg::REG_SCREEN_HEIGHT: prdata = {24'd0, cfg_r.screen_height};
      tcce_pkg::REG_TAB_WIDTH:     prdata = {24'd0, cfg_r.tab_width};
      default:                     prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{line_width: 8'd80, screen_height: 8'd25, tab_width: 8'd8};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tcce_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .init_busy (init_busy),
    .busy      (busy),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop)
  );

  tcce_back #(
    .MAX_LINES (MAX_LINES),
    .MAX_COLS  (MAX_COLS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .cfg_wr     (cfg_wr),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .init_busy  (init_busy),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

// ----- verif/tb_text_canvas_cursor_engine.sv -----
// Self-checking testbench for the text canvas cursor engine.
// Depends on tcce_pkg and text_canvas_cursor_engine; predicts each report in-line.
module tb_text_canvas_cursor_engine;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NLINES = 256;
  localparam int NCOLS  = 128;
  localparam longint CYCLE_LIMIT = 3000000;

  logic            clk;
  logic            rst_n;
  logic            start;
  logic            busy;
  tcce_pkg::in_t   in_item;
  logic            out_strobe;
  tcce_pkg::out_t  out_item;
  logic            psel;
  logic            penable;
  logic            pwrite;
  logic [3:0]      paddr;
  logic [31:0]     pwdata;
  logic [31:0]     prdata;
  logic            pready;

  text_canvas_cursor_engine dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Predictor state.
  logic [15:0] canvas [NLINES*NCOLS];
  int unsigned col_q, line_q, row_q, used_q;
  int unsigned fg_q, bg_q, flags_q, ovf_q;
  int unsigned width_reg, height_reg, tab_reg;

  tcce_pkg::out_t report_q [$];
  int          errors;
  longint      cycles;
  bit          idle_on;

  function automatic int unsigned width_eff();
    int unsigned w;
    w = width_reg;
    if (w == 0) w = 1;
    if (w > NCOLS) w = NCOLS;
    return w;
  endfunction

  function automatic int unsigned height_eff();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  function automatic int unsigned draw_attr();
    int unsigned f, b;
    f = fg_q;
    b = bg_q;
    if (flags_q[2]) begin
      if (flags_q[3]) b = fg_q;
      else begin
        f = bg_q;
        b = fg_q;
      end
    end else if (flags_q[3]) begin
      f = b;
    end
    if (flags_q[0]) f |= 8;
    if (flags_q[1]) b |= 8;
    return ((b << 4) | f) & 8'hff;
  endfunction

  function automatic void poke(int unsigned ln, int unsigned cl, logic [15:0] v);
    if (ln < NLINES && cl < NCOLS) canvas[ln*NCOLS + cl] = v;
  endfunction

  function automatic void descend(int unsigned n);
    int unsigned t;
    t = line_q + n;
    if (t > NLINES - 1) begin
      t = NLINES - 1;
      ovf_q = 1;
    end
    line_q = t;
  endfunction

  function automatic void ascend(int unsigned n);
    line_q = (n > line_q) ? 0 : line_q - n;
  endfunction

  function automatic void next_line();
    descend(1);
    if (row_q + 1 < height_eff()) row_q++;
  endfunction

  function automatic void resolve_wrap(int unsigned n);
    if (n != 0 && col_q >= width_eff()) begin
      col_q = 0;
      next_line();
    end
  endfunction

  function automatic bit place_glyph(int unsigned ch);
    logic [7:0] a;
    if (col_q >= width_eff()) begin
      if (!flags_q[4]) return 1'b0;
      col_q = 0;
      next_line();
    end
    a = 8'(draw_attr());
    poke(line_q, col_q, {a, ch[7:0]});
    col_q++;
    if (line_q >= used_q) used_q = line_q + 1;
    return 1'b1;
  endfunction

  function automatic void blank_span(int unsigned ln, int unsigned a, int unsigned b);
    for (int unsigned i = a; i < b; i++) poke(ln, i, tcce_pkg::BLANK_CELL);
  endfunction

  function automatic void blank_lines(int unsigned a, int unsigned b);
    for (int unsigned i = a; i < b && i < NLINES; i++) blank_span(i, 0, width_eff());
  endfunction

  function automatic void canvas_reset();
    foreach (canvas[i]) canvas[i] = tcce_pkg::BLANK_CELL;
    col_q = 0; line_q = 0; row_q = 0; used_q = 0;
    fg_q = 7; bg_q = 0; flags_q = 5'h10; ovf_q = 0;
    width_reg = 80; height_reg = 25; tab_reg = 8;
  endfunction

  function automatic tcce_pkg::out_t predict_report(tcce_pkg::in_t it);
    tcce_pkg::out_t r;
    int unsigned w, h, n, tx, ty, t, lim, cx, cy;
    logic [15:0] v;
    w = width_eff();
    h = height_eff();
    n = it.move_count;
    tx = it.target_col;
    ty = it.target_row;
    r = '0;
    case (it.mode)
      tcce_pkg::MODE_PUT: begin
        if (it.char_code == tcce_pkg::CH_NUL || it.char_code == tcce_pkg::CH_BEL ||
            it.char_code == tcce_pkg::CH_ESC) begin
        end else if (it.char_code == tcce_pkg::CH_BS) begin
          resolve_wrap(1);
          if (col_q > 0) col_q--;
        end else if (it.char_code == tcce_pkg::CH_TAB) begin
          t = (tab_reg == 0) ? 1 : tab_reg;
          if (t > w) t = w;
          do begin
            if (!place_glyph(tcce_pkg::CH_SPACE)) break;
          end while (col_q % t != 0);
        end else if (it.char_code == tcce_pkg::CH_LF) begin
          next_line();
        end else if (it.char_code == tcce_pkg::CH_CR) begin
          col_q = 0;
        end else begin
          void'(place_glyph(it.char_code));
        end
      end
      tcce_pkg::MODE_UP: begin
        resolve_wrap(n);
        if (n > row_q) n = row_q;
        ascend(n);
        row_q -= n;
      end
      tcce_pkg::MODE_DOWN: begin
        resolve_wrap(n);
        lim = (row_q + 1 < h) ? h - row_q - 1 : 0;
        if (n > lim) n = lim;
        descend(n);
        row_q += n;
      end
      tcce_pkg::MODE_LEFT: begin
        resolve_wrap(n);
        if (n > col_q) n = col_q;
        col_q -= n;
      end
      tcce_pkg::MODE_RIGHT: begin
        resolve_wrap(n);
        lim = (col_q + 1 < w) ? w - col_q - 1 : 0;
        if (n > lim) n = lim;
        col_q += n;
      end
      tcce_pkg::MODE_GOTO: begin
        if (tx >= w) tx = w - 1;
        if (ty >= h) ty = h - 1;
        col_q = tx;
        if (ty >= row_q) descend(ty - row_q);
        else ascend(row_q - ty);
        row_q = ty;
      end
      tcce_pkg::MODE_ATTR: begin
        fg_q = it.fore_color;
        bg_q = it.back_color;
        flags_q = {it.wrap_on, it.hidden_on, it.reverse_on, it.blink_on, it.bold_on};
      end
      tcce_pkg::MODE_CLR_EOL: blank_span(line_q, col_q, w);
      tcce_pkg::MODE_CLR_BOL: blank_span(line_q, 0, col_q);
      tcce_pkg::MODE_CLR_LINE: blank_span(line_q, 0, w);
      tcce_pkg::MODE_CLR_EOS: begin
        blank_span(line_q, col_q, w);
        blank_lines(line_q + 1, used_q);
      end
      tcce_pkg::MODE_CLR_BOS: begin
        blank_span(line_q, 0, col_q);
        if (row_q > 0) blank_lines((row_q > line_q) ? 0 : line_q - row_q, line_q);
      end
      tcce_pkg::MODE_CLR_SCR: blank_lines((row_q > line_q) ? 0 : line_q - row_q, used_q);
      tcce_pkg::MODE_READ: begin
        if (tx >= w) tx = w - 1;
        if (ty > NLINES - 1) ty = NLINES - 1;
        v = canvas[ty*NCOLS + tx];
        r.cell_char = v[7:0];
        r.cell_attr = v[15:8];
      end
      default: begin
      end
    endcase
    if (col_q >= w) begin
      if (flags_q[4]) begin
        cx = 0;
        cy = (row_q + 1 < h) ? row_q + 1 : row_q;
      end else begin
        cx = w - 1;
        cy = row_q;
      end
    end else begin
      cx = col_q;
      cy = row_q;
    end
    r.report_col = cx[6:0];
    r.report_row = cy[7:0];
    r.cur_line = line_q[7:0];
    r.used_lines = used_q[8:0];
    r.line_overflow = ovf_q[0];
    return r;
  endfunction

  // Start stays high between back-to-back items and drops for an idle gap; draining also drops it.
  task automatic idle_burst();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic send_cmd(tcce_pkg::in_t it);
    idle_burst();
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    report_q.push_back(predict_report(it));
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    wait_drained();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= {24'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      tcce_pkg::REG_LINE_WIDTH: begin
        width_reg = val;
        if (col_q > width_eff()) col_q = width_eff();
      end
      tcce_pkg::REG_SCREEN_HEIGHT: begin
        height_reg = val;
        if (row_q >= height_eff()) row_q = height_eff() - 1;
      end
      default: tab_reg = val;
    endcase
  endtask

  function automatic tcce_pkg::in_t random_cmd();
    tcce_pkg::in_t it;
    logic [63:0] raw;
    int unsigned pick;
    raw = {$urandom, $urandom};
    it = raw[$bits(tcce_pkg::in_t)-1:0];
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      it.mode = tcce_pkg::MODE_PUT;
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 6))
          0: it.char_code = tcce_pkg::CH_BS;
          1: it.char_code = tcce_pkg::CH_TAB;
          2: it.char_code = tcce_pkg::CH_LF;
          3: it.char_code = tcce_pkg::CH_CR;
          4: it.char_code = tcce_pkg::CH_NUL;
          5: it.char_code = tcce_pkg::CH_BEL;
          default: it.char_code = tcce_pkg::CH_ESC;
        endcase
      end
    end else if (pick < 60) begin
      it.mode = 4'($urandom_range(tcce_pkg::MODE_UP, tcce_pkg::MODE_RIGHT));
      if ($urandom_range(0, 1)) it.move_count = 8'($urandom_range(0, 4));
    end else if (pick < 68) begin
      it.mode = tcce_pkg::MODE_GOTO;
    end else if (pick < 73) begin
      it.mode = tcce_pkg::MODE_ATTR;
    end else if (pick < 80) begin
      it.mode = 4'($urandom_range(tcce_pkg::MODE_CLR_EOL, tcce_pkg::MODE_CLR_SCR));
    end else if (pick < 97) begin
      it.mode = tcce_pkg::MODE_READ;
      if ($urandom_range(0, 1)) it.target_row = 8'($urandom_range(0, 30));
    end else begin
      it.mode = 4'($urandom_range(tcce_pkg::MODE_READ + 4'd1, 15));
    end
    return it;
  endfunction

  function automatic tcce_pkg::in_t cmd_of(logic [3:0] m, logic [7:0] ch = 8'h41,
                                           logic [7:0] cnt = 8'd0,
                                           logic [7:0] c = 8'd0, logic [7:0] r = 8'd0);
    tcce_pkg::in_t it;
    it = '0;
    it.mode = m;
    it.char_code = ch;
    it.move_count = cnt;
    it.target_col = c;
    it.target_row = r;
    return it;
  endfunction

  task automatic test_directed();
    tcce_pkg::in_t it;
    send_cmd(cmd_of(tcce_pkg::MODE_PUT, 8'hff));
    send_cmd(cmd_of(tcce_pkg::MODE_PUT, tcce_pkg::CH_NUL));
    send_cmd(cmd_of(tcce_pkg::MODE_PUT, tcce_pkg::CH_BEL));
    send_cmd(cmd_of(tcce_pkg::MODE_PUT, tcce_pkg::CH_ESC));
    send_cmd(cmd_of(tcce_pkg::MODE_PUT, tcce_pkg::CH_TAB));
    send_cmd(cmd_of(tcce_pkg::MODE_PUT, tcce_pkg::CH_BS));
    send_cmd(cmd_of(tcce_pkg::MODE_GOTO, 8'h00, 8'd0, 8'd255, 8'd255));
    send_cmd(cmd_of(tcce_pkg::MODE_PUT, 8'h42));
    send_cmd(cmd_of(tcce_pkg::MODE_RIGHT, 8'h00, 8'd3));
    send_cmd(cmd_of(tcce_pkg::MODE_PUT, tcce_pkg::CH_LF));
    send_cmd(cmd_of(tcce_pkg::MODE_PUT, tcce_pkg::CH_CR));
    send_cmd(cmd_of(tcce_pkg::MODE_UP, 8'h00, 8'd255));
    send_cmd(cmd_of(tcce_pkg::MODE_DOWN, 8'h00, 8'd255));
    send_cmd(cmd_of(tcce_pkg::MODE_LEFT, 8'h00, 8'd255));
    it = '1;
    it.mode = tcce_pkg::MODE_ATTR;
    it.wrap_on = 1'b0;
    send_cmd(it);
    send_cmd(cmd_of(tcce_pkg::MODE_GOTO, 8'h00, 8'd0, 8'd78, 8'd3));
    send_cmd(cmd_of(tcce_pkg::MODE_PUT, 8'h43));
    send_cmd(cmd_of(tcce_pkg::MODE_PUT, 8'h44));
    send_cmd(cmd_of(tcce_pkg::MODE_PUT, tcce_pkg::CH_TAB));
    for (int m = tcce_pkg::MODE_CLR_EOL; m <= tcce_pkg::MODE_CLR_SCR; m++)
      send_cmd(cmd_of(4'(m)));
    send_cmd(cmd_of(tcce_pkg::MODE_READ, 8'h00, 8'd0, 8'd255, 8'd255));
    send_cmd(cmd_of(4'd15));
  endtask

  task automatic test_random_block(int count);
    for (int i = 0; i < count; i++) send_cmd(random_cmd());
  endtask

  // Drives the line index into saturation with many line feeds.
  task automatic test_line_saturation();
    for (int i = 0; i < 260; i++) send_cmd(cmd_of(tcce_pkg::MODE_PUT, tcce_pkg::CH_LF));
    send_cmd(cmd_of(tcce_pkg::MODE_CLR_EOS));
    send_cmd(cmd_of(tcce_pkg::MODE_READ, 8'h00, 8'd0, 8'd5, 8'd255));
  endtask

  task automatic test_register_sweep();
    write_reg(tcce_pkg::REG_LINE_WIDTH, 8'd0);
    write_reg(tcce_pkg::REG_SCREEN_HEIGHT, 8'd0);
    write_reg(tcce_pkg::REG_TAB_WIDTH, 8'd0);
    test_random_block(150);
    write_reg(tcce_pkg::REG_LINE_WIDTH, 8'd255);
    write_reg(tcce_pkg::REG_SCREEN_HEIGHT, 8'd255);
    write_reg(tcce_pkg::REG_TAB_WIDTH, 8'd255);
    test_random_block(250);
    write_reg(tcce_pkg::REG_LINE_WIDTH, 8'd128);
    write_reg(tcce_pkg::REG_SCREEN_HEIGHT, 8'd1);
    write_reg(tcce_pkg::REG_TAB_WIDTH, 8'd128);
    test_random_block(150);
    write_reg(tcce_pkg::REG_LINE_WIDTH, 8'd5);
    write_reg(tcce_pkg::REG_SCREEN_HEIGHT, 8'd4);
    write_reg(tcce_pkg::REG_TAB_WIDTH, 8'd3);
    test_random_block(250);
    write_reg(tcce_pkg::REG_LINE_WIDTH, 8'd1);
    write_reg(tcce_pkg::REG_SCREEN_HEIGHT, 8'd255);
    write_reg(tcce_pkg::REG_TAB_WIDTH, 8'd1);
    test_random_block(150);
    write_reg(tcce_pkg::REG_LINE_WIDTH, 8'd80);
    write_reg(tcce_pkg::REG_SCREEN_HEIGHT, 8'd25);
    write_reg(tcce_pkg::REG_TAB_WIDTH, 8'd8);
  endtask

  always @(posedge clk) begin
    tcce_pkg::out_t exp_r;
    if (rst_n && out_strobe) begin
      if (report_q.size() == 0) begin
        $display("%0t: unexpected report, expected none, actual %h", $realtime, out_item);
        errors++;
      end else begin
        exp_r = report_q.pop_front();
        if (out_item.report_col !== exp_r.report_col) begin
          $display("%0t: report_col expected %0d actual %0d", $realtime,
                   exp_r.report_col, out_item.report_col);
          errors++;
        end
        if (out_item.report_row !== exp_r.report_row) begin
          $display("%0t: report_row expected %0d actual %0d", $realtime,
                   exp_r.report_row, out_item.report_row);
          errors++;
        end
        if (out_item.cur_line !== exp_r.cur_line) begin
          $display("%0t: cur_line expected %0d actual %0d", $realtime,
                   exp_r.cur_line, out_item.cur_line);
          errors++;
        end
        if (out_item.used_lines !== exp_r.used_lines) begin
          $display("%0t: used_lines expected %0d actual %0d", $realtime,
                   exp_r.used_lines, out_item.used_lines);
          errors++;
        end
        if (out_item.cell_char !== exp_r.cell_char) begin
          $display("%0t: cell_char expected %h actual %h", $realtime,
                   exp_r.cell_char, out_item.cell_char);
          errors++;
        end
        if (out_item.cell_attr !== exp_r.cell_attr) begin
          $display("%0t: cell_attr expected %h actual %h", $realtime,
                   exp_r.cell_attr, out_item.cell_attr);
          errors++;
        end
        if (out_item.line_overflow !== exp_r.line_overflow) begin
          $display("%0t: line_overflow expected %b actual %b", $realtime,
                   exp_r.line_overflow, out_item.line_overflow);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    errors = 0;
    cycles = 0;
    idle_on = 1'b1;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    canvas_reset();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_register_sweep();
    test_line_saturation();
    test_random_block(200);
    // The tail of the run keeps the command channel saturated.
    idle_on = 1'b0;
    test_random_block(100);
    wait_drained();
    if (errors == 0 && report_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
